[design/bmp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants for the binomial coefficient modulo prime block:
// controller states, multiplier operand selects and the command/status bundles.
// ----------------------------------------------------------------------------
package bmp_pkg;

    // Reset value of the modulus register (a prime that fits in 31 bits).
    localparam logic [30:0] C_MODULUS_RESET = 31'd1000000007;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FACT_GO,
        S_FACT_WAIT,
        S_FACT_END,
        S_POW_INIT,
        S_POW_CHK,
        S_SQR_GO,
        S_SQR_WAIT,
        S_MULB_GO,
        S_MULB_WAIT,
        S_RES_GO,
        S_RES_WAIT,
        S_DONE
    } t_state;

    // Operand pair fed to the shared modular multiplier.
    typedef enum logic [1:0] {
        MS_FACT,   // running factorial times k
        MS_SQR,    // accumulator squared
        MS_BASE,   // base times accumulator
        MS_RES     // partial result times accumulator
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     res_zero;
        logic     fact_init;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     fact_upd;
        logic     res_from_fact;
        logic     pow_init;
        logic     pow_sel_r;
        logic     acc_upd;
        logic     bit_dec;
        logic     res_upd;
    } t_cmd;

    typedef struct packed {
        logic invalid;
        logic n_zero;
        logic k_last;
        logic base_zero;
        logic exp_bit;
        logic bit_last;
        logic mul_done;
    } t_status;

endpackage
`default_nettype wire

[design/bmp_modmul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_modmul
// Bit-serial interleaved modular multiplier: a * b mod p, one bit of b per
// cycle, most significant bit first. Operand a must be below p.
// ----------------------------------------------------------------------------
module bmp_modmul #(
    parameter int MOD_BITS = 31,
    parameter int B_BITS   = 31
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [MOD_BITS-1:0]          i_a,
    input  wire logic [B_BITS-1:0]            i_b,
    input  wire logic [$clog2(B_BITS+1)-1:0]  i_nbits,
    input  wire logic [MOD_BITS-1:0]          i_modulus,
    output logic                              o_done,
    output logic [MOD_BITS-1:0]               o_product
);

    localparam int CNT_W = $clog2(B_BITS + 1);

    logic                r_run;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [MOD_BITS-1:0] r_a;
    logic [B_BITS-1:0]   r_b;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] n_acc;

    logic [MOD_BITS+1:0] w_sum;
    logic [MOD_BITS+1:0] w_p1;
    logic [MOD_BITS+1:0] w_p2;

    // The sum 2*acc + a stays below 3p, so at most two subtractions of p.
    always_comb begin
        w_p1  = {2'b00, i_modulus};
        w_p2  = {1'b0, i_modulus, 1'b0};
        w_sum = {1'b0, r_acc, 1'b0} + (r_b[B_BITS-1] ? {2'b00, r_a} : '0);
        priority if (w_sum >= w_p2) begin
            n_acc = MOD_BITS'(w_sum - w_p2);
        end else if (w_sum >= w_p1) begin
            n_acc = MOD_BITS'(w_sum - w_p1);
        end else begin
            n_acc = MOD_BITS'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= i_nbits;
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_run) begin
            r_acc <= n_acc;
            r_b   <= r_b << 1;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule
`default_nettype wire

[design/bmp_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_dpath
// Datapath: operand registers, running factorial with its two captures,
// Fermat exponentiation accumulator, partial result and the shared multiplier.
// ----------------------------------------------------------------------------
module bmp_dpath #(
    parameter int ARG_BITS = 20,
    parameter int MOD_BITS = 31
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bmp_pkg::t_cmd       i_cmd,
    input  wire logic [ARG_BITS-1:0] i_n_value,
    input  wire logic [ARG_BITS-1:0] i_r_value,
    input  wire logic [MOD_BITS-1:0] i_modulus,
    output bmp_pkg::t_status         o_status,
    output logic [MOD_BITS-1:0]      o_result
);

    localparam int B_BITS = (ARG_BITS > MOD_BITS) ? ARG_BITS : MOD_BITS;
    localparam int CNT_W  = $clog2(B_BITS + 1);
    localparam int BIT_W  = $clog2(MOD_BITS);

    logic [ARG_BITS-1:0] r_n;
    logic [ARG_BITS-1:0] r_r;
    logic [ARG_BITS-1:0] r_nr;
    logic [ARG_BITS-1:0] r_k;
    logic [MOD_BITS-1:0] r_exp;
    logic [MOD_BITS-1:0] r_fact;
    logic [MOD_BITS-1:0] r_fact_r;
    logic [MOD_BITS-1:0] r_fact_nr;
    logic [MOD_BITS-1:0] r_base;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_res;
    logic [BIT_W-1:0]    r_bit;

    logic [MOD_BITS-1:0] w_mul_a;
    logic [B_BITS-1:0]   w_mul_b;
    logic [CNT_W-1:0]    w_mul_nbits;
    logic                w_mul_done;
    logic [MOD_BITS-1:0] w_mul_prod;
    logic [B_BITS-1:0]   w_acc_b;

    // Multiplier operands are left-aligned so the scan starts at the top bit.
    assign w_acc_b = B_BITS'(r_acc) << (B_BITS - MOD_BITS);

    always_comb begin
        unique case (i_cmd.mul_sel)
            bmp_pkg::MS_FACT: begin
                w_mul_a     = r_fact;
                w_mul_b     = B_BITS'(r_k) << (B_BITS - ARG_BITS);
                w_mul_nbits = CNT_W'(ARG_BITS);
            end
            bmp_pkg::MS_SQR: begin
                w_mul_a     = r_acc;
                w_mul_b     = w_acc_b;
                w_mul_nbits = CNT_W'(MOD_BITS);
            end
            bmp_pkg::MS_BASE: begin
                w_mul_a     = r_base;
                w_mul_b     = w_acc_b;
                w_mul_nbits = CNT_W'(MOD_BITS);
            end
            default: begin
                w_mul_a     = r_res;
                w_mul_b     = w_acc_b;
                w_mul_nbits = CNT_W'(MOD_BITS);
            end
        endcase
    end

    bmp_modmul #(
        .MOD_BITS (MOD_BITS),
        .B_BITS   (B_BITS)
    ) u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .i_nbits   (w_mul_nbits),
        .i_modulus (i_modulus),
        .o_done    (w_mul_done),
        .o_product (w_mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= i_n_value;
            r_r   <= i_r_value;
            r_nr  <= i_n_value - i_r_value;
            r_exp <= i_modulus - MOD_BITS'(2);
        end
        if (i_cmd.fact_init) begin
            r_k       <= ARG_BITS'(1);
            r_fact    <= MOD_BITS'(1);
            r_fact_r  <= MOD_BITS'(1);
            r_fact_nr <= MOD_BITS'(1);
        end else if (i_cmd.fact_upd) begin
            r_k    <= r_k + ARG_BITS'(1);
            r_fact <= w_mul_prod;
            if (r_k == r_r) begin
                r_fact_r <= w_mul_prod;
            end
            if (r_k == r_nr) begin
                r_fact_nr <= w_mul_prod;
            end
        end
        if (i_cmd.pow_init) begin
            r_base <= i_cmd.pow_sel_r ? r_fact_r : r_fact_nr;
            r_acc  <= MOD_BITS'(1);
            r_bit  <= BIT_W'(MOD_BITS - 1);
        end else begin
            if (i_cmd.acc_upd) begin
                r_acc <= w_mul_prod;
            end
            if (i_cmd.bit_dec) begin
                r_bit <= r_bit - BIT_W'(1);
            end
        end
        if (i_cmd.res_zero) begin
            r_res <= '0;
        end else if (i_cmd.res_from_fact) begin
            r_res <= r_fact;
        end else if (i_cmd.res_upd) begin
            r_res <= w_mul_prod;
        end
    end

    // A modulus below two, r above n, or n at or above p all give zero.
    always_comb begin
        o_status.invalid   = (i_modulus < MOD_BITS'(2)) || (r_r > r_n)
                             || (B_BITS'(r_n) >= B_BITS'(i_modulus));
        o_status.n_zero    = (r_n == '0);
        o_status.k_last    = (r_k == r_n);
        o_status.base_zero = (r_base == '0);
        o_status.exp_bit   = r_exp[r_bit];
        o_status.bit_last  = (r_bit == '0);
        o_status.mul_done  = w_mul_done;
    end

    assign o_result = r_res;

endmodule
`default_nettype wire

[design/bmp_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_ctrl
// Controller: sequences the factorial pass, two Fermat inversions and the
// final products, and issues the result strobe.
// ----------------------------------------------------------------------------
module bmp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire bmp_pkg::t_status i_status,
    output bmp_pkg::t_cmd         o_cmd,
    output logic                  o_busy,
    output logic                  o_result_valid
);

    bmp_pkg::t_state r_state;
    bmp_pkg::t_state n_state;
    logic            r_phase;
    logic            n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmp_pkg::S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // Next state. The phase bit tells which captured factorial is inverted.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            bmp_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = bmp_pkg::S_CHECK;
                end
            end
            bmp_pkg::S_CHECK: begin
                if (i_status.invalid) begin
                    n_state = bmp_pkg::S_DONE;
                end else if (i_status.n_zero) begin
                    n_state = bmp_pkg::S_FACT_END;
                end else begin
                    n_state = bmp_pkg::S_FACT_GO;
                end
            end
            bmp_pkg::S_FACT_GO: n_state = bmp_pkg::S_FACT_WAIT;
            bmp_pkg::S_FACT_WAIT: begin
                if (i_status.mul_done) begin
                    n_state = i_status.k_last ? bmp_pkg::S_FACT_END : bmp_pkg::S_FACT_GO;
                end
            end
            bmp_pkg::S_FACT_END: begin
                n_phase = 1'b0;
                n_state = bmp_pkg::S_POW_INIT;
            end
            bmp_pkg::S_POW_INIT: n_state = bmp_pkg::S_POW_CHK;
            bmp_pkg::S_POW_CHK: begin
                n_state = i_status.base_zero ? bmp_pkg::S_DONE : bmp_pkg::S_SQR_GO;
            end
            bmp_pkg::S_SQR_GO: n_state = bmp_pkg::S_SQR_WAIT;
            bmp_pkg::S_SQR_WAIT: begin
                if (i_status.mul_done) begin
                    priority if (i_status.exp_bit) begin
                        n_state = bmp_pkg::S_MULB_GO;
                    end else if (i_status.bit_last) begin
                        n_state = bmp_pkg::S_RES_GO;
                    end else begin
                        n_state = bmp_pkg::S_SQR_GO;
                    end
                end
            end
            bmp_pkg::S_MULB_GO: n_state = bmp_pkg::S_MULB_WAIT;
            bmp_pkg::S_MULB_WAIT: begin
                if (i_status.mul_done) begin
                    n_state = i_status.bit_last ? bmp_pkg::S_RES_GO : bmp_pkg::S_SQR_GO;
                end
            end
            bmp_pkg::S_RES_GO: n_state = bmp_pkg::S_RES_WAIT;
            bmp_pkg::S_RES_WAIT: begin
                if (i_status.mul_done) begin
                    if (r_phase) begin
                        n_state = bmp_pkg::S_DONE;
                    end else begin
                        n_phase = 1'b1;
                        n_state = bmp_pkg::S_POW_INIT;
                    end
                end
            end
            bmp_pkg::S_DONE: n_state = bmp_pkg::S_IDLE;
            default: n_state = bmp_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd          = '0;
        o_busy         = (r_state != bmp_pkg::S_IDLE);
        o_result_valid = 1'b0;
        unique case (r_state)
            bmp_pkg::S_IDLE: o_cmd.load = i_start;
            bmp_pkg::S_CHECK: begin
                o_cmd.res_zero  = i_status.invalid;
                o_cmd.fact_init = 1'b1;
            end
            bmp_pkg::S_FACT_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = bmp_pkg::MS_FACT;
            end
            bmp_pkg::S_FACT_WAIT: o_cmd.fact_upd = i_status.mul_done;
            bmp_pkg::S_FACT_END: o_cmd.res_from_fact = 1'b1;
            bmp_pkg::S_POW_INIT: begin
                o_cmd.pow_init  = 1'b1;
                o_cmd.pow_sel_r = r_phase;
            end
            bmp_pkg::S_POW_CHK: o_cmd.res_zero = i_status.base_zero;
            bmp_pkg::S_SQR_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = bmp_pkg::MS_SQR;
            end
            bmp_pkg::S_SQR_WAIT: begin
                o_cmd.acc_upd = i_status.mul_done;
                o_cmd.bit_dec = i_status.mul_done && !i_status.exp_bit
                                && !i_status.bit_last;
            end
            bmp_pkg::S_MULB_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = bmp_pkg::MS_BASE;
            end
            bmp_pkg::S_MULB_WAIT: begin
                o_cmd.acc_upd = i_status.mul_done;
                o_cmd.bit_dec = i_status.mul_done && !i_status.bit_last;
            end
            bmp_pkg::S_RES_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = bmp_pkg::MS_RES;
            end
            bmp_pkg::S_RES_WAIT: o_cmd.res_upd = i_status.mul_done;
            bmp_pkg::S_DONE: o_result_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[design/binomial_mod_prime_top.sv]
`default_nettype none
// When the answer is zero up front (r above n, n at or above p, p below 2), the controller goes
// from the check straight to the result strobe. Otherwise the run time grows with n and with the
// number of set bits in p-2, and is set by the bit-serial modular multiplier, one operand bit
// per cycle and shared by every product. One item at a time: start is taken again in the
// cycle after the result strobe. The receiver cannot stall.
// Synchronous active-low reset returns the controller to idle and the modulus to 1000000007.
// ----------------------------------------------------------------------------
// binomial_mod_prime_top
// Computes C(n, r) mod p by a factorial pass and two Fermat inversions, with p
// held in a configuration register.
// ----------------------------------------------------------------------------
module binomial_mod_prime_top #(
    parameter int ARG_BITS = 20,
    parameter int MOD_BITS = 31
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [ARG_BITS-1:0] i_n_value,
    input  wire logic [ARG_BITS-1:0] i_r_value,
    output logic                     o_result_valid,
    output logic [MOD_BITS-1:0]      o_binomial,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [MOD_BITS-1:0] i_cfg_data
);

    logic [MOD_BITS-1:0] r_modulus;
    bmp_pkg::t_cmd       w_cmd;
    bmp_pkg::t_status    w_status;
    logic                w_start;

    // A modulus transfer waits while start is high or an item is in flight, so every item
    // sees one modulus from start to end.
    assign o_cfg_ready = !busy && !start;
    assign w_start     = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= bmp_pkg::C_MODULUS_RESET[MOD_BITS-1:0];
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_modulus <= i_cfg_data;
        end
    end

    bmp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_status       (w_status),
        .o_cmd          (w_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    bmp_dpath #(
        .ARG_BITS (ARG_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_n_value (i_n_value),
        .i_r_value (i_r_value),
        .i_modulus (r_modulus),
        .o_status  (w_status),
        .o_result  (o_binomial)
    );

`ifndef SYNTHESIS
    // A result is only ever shown while an item is in flight.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe while idle");

    // An accepted item makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // Every result is fully reduced modulo a usable modulus.
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (r_modulus >= MOD_BITS'(2))) |-> (o_binomial < r_modulus))
        else $error("result not reduced modulo p");
`endif

endmodule
`default_nettype wire

[dv/tb_binomial_mod_prime_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binomial_mod_prime_top
// Self-checking bench for the binomial coefficient modulo prime block. A short
// table of directed items covers the corner cases, then constrained-by-hand
// random items run under three sender idling mixes. Every result is compared
// with an in-bench calculation of C(n, r) mod p that tracks the modulus
// register across writes.
// ----------------------------------------------------------------------------
module tb_binomial_mod_prime_top;

    localparam int          ARG_BITS    = 20;
    localparam int          MOD_BITS    = 31;
    localparam int          N_DIRECTED  = 23;
    localparam int          CYCLE_LIMIT = 4000000;
    // Random items that take the full calculation keep n this small to bound run time.
    localparam int          SLOW_N_MAX  = 40;
    localparam logic [19:0] ARG_MAX     = 20'hFFFFF;
    localparam logic [30:0] MOD_MAX     = 31'h7FFFFFFF;

    typedef struct packed {
        logic        set_mod;
        logic [30:0] modulus;
        logic [19:0] n;
        logic [19:0] r;
        logic        known;
        logic [30:0] binomial;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ARG_BITS-1:0] i_n_value = '0;
    logic [ARG_BITS-1:0] i_r_value = '0;
    logic                o_result_valid;
    logic [MOD_BITS-1:0] o_binomial;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [MOD_BITS-1:0] i_cfg_data = '0;

    logic [30:0] binomial_due [$];
    logic [30:0] due_head;
    logic [30:0] cur_modulus = bmp_pkg::C_MODULUS_RESET;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          gap_pct = 26;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{1'b0, 31'd0,             20'd0,       20'd0,   1'b1, 31'd1},
        '{1'b0, 31'd0,             20'd1,       20'd0,   1'b1, 31'd1},
        '{1'b0, 31'd0,             20'd1,       20'd1,   1'b1, 31'd1},
        '{1'b0, 31'd0,             20'd0,       20'd1,   1'b1, 31'd0},
        '{1'b0, 31'd0,             20'd0,       ARG_MAX, 1'b1, 31'd0},
        '{1'b0, 31'd0,             20'hFFFFE,   ARG_MAX, 1'b1, 31'd0},
        '{1'b0, 31'd0,             20'd5,       20'd2,   1'b1, 31'd10},
        '{1'b0, 31'd0,             20'd20,      20'd10,  1'b1, 31'd184756},
        '{1'b0, 31'd0,             20'd1000,    20'd1,   1'b1, 31'd1000},
        '{1'b0, 31'd0,             20'd100,     20'd50,  1'b0, 31'd0},
        '{1'b0, 31'd0,             20'd7,       20'd7,   1'b1, 31'd1},
        '{1'b1, 31'd13,            20'd20,      20'd3,   1'b1, 31'd0},
        '{1'b0, 31'd0,             20'd13,      20'd0,   1'b1, 31'd0},
        '{1'b0, 31'd0,             20'd12,      20'd5,   1'b0, 31'd0},
        '{1'b1, 31'd2,             20'd1,       20'd0,   1'b1, 31'd1},
        '{1'b0, 31'd0,             ARG_MAX,     ARG_MAX, 1'b1, 31'd0},
        '{1'b1, 31'd1,             20'd0,       20'd0,   1'b1, 31'd0},
        '{1'b1, 31'd0,             20'd5,       20'd2,   1'b1, 31'd0},
        '{1'b1, MOD_MAX,           20'd10,      20'd5,   1'b1, 31'd252},
        '{1'b0, 31'd0,             20'd3,       20'd1,   1'b1, 31'd3},
        '{1'b1, 31'd6,             20'd5,       20'd2,   1'b0, 31'd0},
        '{1'b0, 31'd0,             20'd5,       20'd3,   1'b0, 31'd0},
        '{1'b1, bmp_pkg::C_MODULUS_RESET, 20'd20, 20'd0, 1'b1, 31'd1}
    };

    binomial_mod_prime_top #(
        .ARG_BITS(ARG_BITS),
        .MOD_BITS(MOD_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_n_value     (i_n_value),
        .i_r_value     (i_r_value),
        .o_result_valid(o_result_valid),
        .o_binomial    (o_binomial),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint unsigned mul_mod(input longint unsigned a,
                                                input longint unsigned b,
                                                input longint unsigned p);
        return (a * b) % p;
    endfunction

    // Square-and-multiply over all 31 exponent bits, top bit first.
    function automatic longint unsigned pow_mod(input longint unsigned base,
                                                input longint unsigned ex,
                                                input longint unsigned p);
        longint unsigned acc;
        longint unsigned b;
        acc = 1 % p;
        b   = base % p;
        if (b == 0) return 0;
        for (int bit_idx = MOD_BITS - 1; bit_idx >= 0; bit_idx--) begin
            acc = mul_mod(acc, acc, p);
            if ((ex >> bit_idx) & 1) acc = mul_mod(acc, b, p);
        end
        return acc;
    endfunction

    function automatic logic [30:0] calc_binomial(input logic [19:0] n,
                                                  input logic [19:0] r,
                                                  input logic [30:0] modulus);
        longint unsigned p;
        longint unsigned fact;
        longint unsigned fact_r;
        longint unsigned fact_nr;
        longint unsigned res;
        longint unsigned ex;
        p       = modulus;
        fact    = 1;
        fact_r  = 1;
        fact_nr = 1;
        if (p < 2 || r > n) return '0;
        for (longint unsigned k = 1; k <= n; k++) begin
            fact = mul_mod(fact, k, p);
            if (k == r) fact_r = fact;
            if (k == n - r) fact_nr = fact;
        end
        ex  = (p - 2) & 64'h7FFF_FFFF;
        res = mul_mod(fact % p, pow_mod(fact_nr, ex, p), p);
        res = mul_mod(res, pow_mod(fact_r, ex, p), p);
        return res[30:0];
    endfunction

    function automatic logic [30:0] pick_modulus();
        case ($urandom_range(0, 9))
            0: return 31'($urandom_range(0, 1));
            1, 2, 3: begin
                case ($urandom_range(0, 7))
                    0: return 31'd2;
                    1: return 31'd3;
                    2: return 31'd5;
                    3: return 31'd7;
                    4: return 31'd13;
                    5: return 31'd31;
                    6: return 31'd61;
                    default: return 31'd251;
                endcase
            end
            4: return 31'd65521;
            5: return bmp_pkg::C_MODULUS_RESET;
            6: return 31'd998244353;
            7: return MOD_MAX;
            // Arbitrary values, mostly composite.
            default: return 31'($urandom());
        endcase
    endfunction

    // Lowers start, waits until every outstanding result has come back, then
    // performs one modulus register transfer.
    task automatic write_modulus(input logic [30:0] value);
        start <= 1'b0;
        while (binomial_due.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        cur_modulus = value;
        @(posedge i_clk);
    endtask

    task automatic issue_item(input logic [19:0] n, input logic [19:0] r,
                              input logic known, input logic [30:0] want);
        logic [30:0] due;
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_n_value <= n;
        i_r_value <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        due          = known ? want : calc_binomial(n, r, cur_modulus);
        binomial_due = {binomial_due, due};
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (binomial_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result with none pending: binomial=%0d", o_binomial);
            end else begin
                due_head = binomial_due.pop_front();
                if (o_binomial !== due_head) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("binomial mismatch: expected %0d, got %0d",
                                 due_head, o_binomial);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [19:0] n;
        logic [19:0] r;
        logic [19:0] swap;
        int          mode;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_mod) write_modulus(directed_rows[i].modulus);
            issue_item(directed_rows[i].n, directed_rows[i].r,
                       directed_rows[i].known, directed_rows[i].binomial);
        end

        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = (phase == 0) ? 26 : (phase == 1) ? 78 : 0;
            for (int blk = 0; blk < 4; blk++) begin
                write_modulus(pick_modulus());
                for (int j = 0; j < 6; j++) begin
                    mode = $urandom_range(0, 9);
                    if (mode < 6 && cur_modulus >= 2) begin
                        // Well-formed item that runs the whole calculation.
                        n = 20'($urandom_range(0, (cur_modulus - 1 < SLOW_N_MAX) ?
                                                  int'(cur_modulus) - 1 : SLOW_N_MAX));
                        r = 20'($urandom_range(0, int'(n)));
                    end else if (mode < 8) begin
                        n = 20'($urandom_range(0, 20'hFFFFE));
                        r = 20'($urandom_range(int'(n) + 1, int'(ARG_MAX)));
                    end else begin
                        n = 20'($urandom());
                        r = 20'($urandom());
                        // Keep full-range values off the long factorial pass.
                        if (cur_modulus >= 2 && r <= n && n < cur_modulus &&
                            n > SLOW_N_MAX) begin
                            if (r < n) begin
                                swap = n;
                                n    = r;
                                r    = swap;
                            end else begin
                                n = n & 20'd31;
                                r = n;
                            end
                        end
                    end
                    issue_item(n, r, 1'b0, '0);
                end
            end
        end

        start <= 1'b0;
        while (binomial_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && binomial_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
